// ===== hdl/tqle_pkg.sv =====
// tqle_pkg: shared types and constants of the tabular q-learning engine
// field widths, op codes, register indexes, beat payloads, controller commands
// no dependencies
`timescale 1ns / 1ps

package tqle_pkg;

  // field widths of a beat
  localparam int STATE_W  = 8;
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 16;
  localparam int RATE_W   = 16;

  // table geometry follows from the index fields
  localparam int STATES   = 1 << STATE_W;
  localparam int ACTIONS  = 1 << ACTION_W;
  localparam int Q_ADDR_W = STATE_W + ACTION_W;
  localparam int Q_DEPTH  = STATES * ACTIONS;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT      = 1'b1;

  localparam logic [RATE_W-1:0] ONE_Q15           = 16'h8000;
  localparam logic [RATE_W-1:0] LEARNING_RATE_RST = 16'd3277;
  localparam logic [RATE_W-1:0] DISCOUNT_RST      = 16'd29491;

  // -10.0 in q8.8
  localparam logic [VALUE_W-1:0] Q_RESET_VALUE = 16'hF600;

  typedef enum logic [1:0] {
    OP_LEARN  = 2'd0,
    OP_CHOOSE = 2'd1,
    OP_WRITE  = 2'd2,
    OP_NOP    = 2'd3
  } tqle_op_e;

  typedef struct packed {
    tqle_op_e                   op;
    logic [STATE_W-1:0]         state_index;
    logic [ACTION_W-1:0]        action_index;
    logic signed [VALUE_W-1:0]  reward;
    logic [STATE_W-1:0]         next_state;
    logic                       bootstrap;
    logic signed [VALUE_W-1:0]  write_value;
  } tqle_req_t;

  typedef struct packed {
    logic [ACTION_W-1:0]        best_action;
    logic signed [VALUE_W-1:0]  result_value;
  } tqle_rsp_t;

  // table port operation in the current cycle
  typedef enum logic [2:0] {
    MEM_IDLE,
    MEM_CLEAR,
    MEM_SCAN,
    MEM_PRED,
    MEM_WRITE,
    MEM_UPDATE
  } tqle_mem_e;

  typedef struct packed {
    logic                 load;
    tqle_mem_e            mem;
    logic [Q_ADDR_W-1:0]  idx;
    logic                 mul_disc;
    logic                 calc_target;
    logic                 calc_delta;
    logic                 mul_step;
    logic                 out_load;
  } tqle_cmd_t;

endpackage

// ===== hdl/tqle_if.sv =====
// tqle_if: request and response channels of the q-learning engine
// valid/ready handshake with a struct payload, depends on tqle_pkg
`timescale 1ns / 1ps

interface tqle_req_if;
  import tqle_pkg::*;

  logic      valid;
  logic      ready;
  tqle_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tqle_rsp_if;
  import tqle_pkg::*;

  logic      valid;
  logic      ready;
  tqle_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/tqle_ctrl.sv =====
// tqle_ctrl: sequencer of the q-learning engine
// steps the table port and arithmetic through each op, depends on tqle_pkg
`timescale 1ns / 1ps

module tqle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  tqle_pkg::tqle_op_e  in_op_i,
  input  logic                in_boot_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output tqle_pkg::tqle_cmd_t cmd_o
);
  import tqle_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_PRED,
    ST_TGT,
    ST_DELTA,
    ST_MUL,
    ST_UPD,
    ST_WRITE,
    ST_DONE
  } ctrl_state_e;

  localparam logic [Q_ADDR_W-1:0] CLEAR_LAST = Q_ADDR_W'(Q_DEPTH - 1);
  localparam logic [ACTION_W-1:0] SCAN_LAST  = ACTION_W'(ACTIONS - 1);

  ctrl_state_e         state_q, state_d;
  logic [Q_ADDR_W-1:0] cnt_q, cnt_d;
  tqle_op_e            op_q, op_d;
  logic                boot_q, boot_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                out_load;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    boot_d      = boot_q;
    out_valid_d = out_valid_q;

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CLEAR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_d   = in_op_i;
          boot_d = in_boot_i;
          cnt_d  = '0;
          unique case (in_op_i)
            OP_LEARN:  state_d = in_boot_i ? ST_SCAN : ST_PRED;
            OP_CHOOSE: state_d = ST_SCAN;
            OP_WRITE:  state_d = ST_WRITE;
            OP_NOP:    state_d = ST_DONE;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[ACTION_W-1:0] == SCAN_LAST) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_d = (op_q == OP_CHOOSE) ? ST_DONE : ST_PRED;
      ST_PRED:     state_d = ST_TGT;
      ST_TGT:      state_d = ST_DELTA;
      ST_DELTA:    state_d = ST_MUL;
      ST_MUL:      state_d = ST_UPD;
      ST_UPD:      state_d = ST_DONE;
      ST_WRITE:    state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      op_q        <= OP_NOP;
      boot_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      op_q        <= op_d;
      boot_q      <= boot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.mem         = MEM_IDLE;
    cmd_o.idx         = cnt_q;
    cmd_o.load        = accept;
    cmd_o.out_load    = out_load;
    unique case (state_q)
      ST_CLEAR: cmd_o.mem = MEM_CLEAR;
      ST_SCAN:  cmd_o.mem = MEM_SCAN;
      ST_PRED: begin
        cmd_o.mem      = MEM_PRED;
        cmd_o.mul_disc = boot_q;
      end
      ST_TGT:   cmd_o.calc_target = 1'b1;
      ST_DELTA: cmd_o.calc_delta  = 1'b1;
      ST_MUL:   cmd_o.mul_step    = 1'b1;
      ST_UPD:   cmd_o.mem         = MEM_UPDATE;
      ST_WRITE: cmd_o.mem         = MEM_WRITE;
      default:  cmd_o.mem         = MEM_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/tqle_datapath.sv =====
// tqle_datapath: q table, max search, update arithmetic and result register
// driven by tqle_ctrl commands, depends on tqle_pkg
`timescale 1ns / 1ps

module tqle_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tqle_pkg::tqle_cmd_t            cmd_i,
  input  tqle_pkg::tqle_req_t            req_data_i,
  input  logic                           cfg_we_i,
  input  logic [tqle_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tqle_pkg::RATE_W-1:0]    cfg_data_i,
  output tqle_pkg::tqle_rsp_t            rsp_data_o
);
  import tqle_pkg::*;

  localparam int FRAC_W  = 15;
  localparam int PROD1_W = VALUE_W + RATE_W + 1;
  localparam int TGT_W   = PROD1_W - FRAC_W;
  localparam int DELTA_W = TGT_W + 1;
  localparam int PROD2_W = DELTA_W + RATE_W + 1;
  localparam int STEP_W  = PROD2_W - FRAC_W;
  localparam int NV_W    = STEP_W + 1;

  localparam logic signed [PROD1_W-1:0] ROUND1 = PROD1_W'(1 << (FRAC_W - 1));
  localparam logic signed [PROD2_W-1:0] ROUND2 = PROD2_W'(1 << (FRAC_W - 1));
  localparam logic signed [VALUE_W-1:0] V_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] V_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};

  tqle_req_t                  item_q;
  logic [RATE_W-1:0]          alpha_q, gamma_q;
  logic [VALUE_W-1:0]         mem [Q_DEPTH];
  logic signed [VALUE_W-1:0]  rdata_q;
  logic                       cmp_vld_q;
  logic [ACTION_W-1:0]        cmp_k_q;
  logic signed [VALUE_W-1:0]  best_q;
  logic [ACTION_W-1:0]        arg_q;
  logic signed [PROD1_W-1:0]  prod1_q;
  logic signed [VALUE_W-1:0]  pred_q;
  logic signed [TGT_W-1:0]    target_q;
  logic signed [DELTA_W-1:0]  delta_q;
  logic signed [PROD2_W-1:0]  prod2_q;
  logic signed [VALUE_W-1:0]  nv_q;
  tqle_rsp_t                  rsp_q;

  logic [Q_ADDR_W-1:0]        mem_addr;
  logic [VALUE_W-1:0]         mem_wdata;
  logic                       mem_we, mem_re;
  logic [STATE_W-1:0]         scan_state;
  logic [RATE_W-1:0]          cfg_clamped;
  logic signed [PROD1_W-1:0]  disc_sum;
  logic signed [TGT_W-1:0]    disc_ext, reward_ext;
  logic signed [PROD2_W-1:0]  step_sum;
  logic signed [NV_W-1:0]     nv_full;
  logic signed [VALUE_W-1:0]  nv_sat;

  // rates above one act as one
  assign cfg_clamped = (cfg_data_i > ONE_Q15) ? ONE_Q15 : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= LEARNING_RATE_RST;
      gamma_q <= DISCOUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEARNING_RATE: alpha_q <= cfg_clamped;
        CFG_DISCOUNT:      gamma_q <= cfg_clamped;
        default: ;
      endcase
    end
  end

  assign scan_state = (item_q.op == OP_CHOOSE) ? item_q.state_index : item_q.next_state;

  always_comb begin
    mem_addr  = {item_q.state_index, item_q.action_index};
    mem_wdata = item_q.write_value;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    unique case (cmd_i.mem)
      MEM_CLEAR: begin
        mem_addr  = cmd_i.idx;
        mem_wdata = Q_RESET_VALUE;
        mem_we    = 1'b1;
      end
      MEM_SCAN: begin
        mem_addr = {scan_state, cmd_i.idx[ACTION_W-1:0]};
        mem_re   = 1'b1;
      end
      MEM_PRED:   mem_re = 1'b1;
      MEM_WRITE:  mem_we = 1'b1;
      MEM_UPDATE: begin
        mem_wdata = nv_sat;
        mem_we    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // compare stage trails the read, working on its data in the cycle after it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= (cmd_i.mem == MEM_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_k_q <= cmd_i.idx[ACTION_W-1:0];
    if (cmp_vld_q && (cmp_k_q == '0 || rdata_q > best_q)) begin
      best_q <= rdata_q;
      arg_q  <= cmp_k_q;
    end
  end

  // target = reward + round(max * gamma) with bootstrap, else reward; delta = target - q(s,a)
  assign disc_sum   = prod1_q + ROUND1;
  assign disc_ext   = disc_sum[PROD1_W-1:FRAC_W];
  assign reward_ext = {{(TGT_W-VALUE_W){item_q.reward[VALUE_W-1]}}, item_q.reward};

  // new = q(s,a) + round(delta * alpha), saturated
  assign step_sum = prod2_q + ROUND2;
  assign nv_full  = {{(NV_W-VALUE_W){pred_q[VALUE_W-1]}}, pred_q}
                  + {step_sum[PROD2_W-1], step_sum[PROD2_W-1:FRAC_W]};

  always_comb begin
    nv_sat = nv_full[VALUE_W-1:0];
    if (nv_full[NV_W-1:VALUE_W-1] != {(NV_W-VALUE_W+1){nv_full[NV_W-1]}}) begin
      nv_sat = nv_full[NV_W-1] ? V_MIN : V_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= req_data_i;
    end
    if (cmd_i.mul_disc) begin
      prod1_q <= best_q * $signed({1'b0, gamma_q});
    end else if (cmd_i.mem == MEM_PRED) begin
      prod1_q <= '0;
    end
    if (cmd_i.calc_target) begin
      pred_q   <= rdata_q;
      target_q <= reward_ext + (item_q.bootstrap ? disc_ext : TGT_W'(0));
    end
    if (cmd_i.calc_delta) begin
      delta_q <= {target_q[TGT_W-1], target_q}
               - {{(DELTA_W-VALUE_W){pred_q[VALUE_W-1]}}, pred_q};
    end
    if (cmd_i.mul_step) begin
      prod2_q <= delta_q * $signed({1'b0, alpha_q});
    end
    if (cmd_i.mem == MEM_UPDATE) begin
      nv_q <= nv_sat;
    end
    if (cmd_i.out_load) begin
      unique case (item_q.op)
        OP_LEARN: begin
          rsp_q.best_action  <= '0;
          rsp_q.result_value <= nv_q;
        end
        OP_CHOOSE: begin
          rsp_q.best_action  <= arg_q;
          rsp_q.result_value <= best_q;
        end
        OP_WRITE: begin
          rsp_q.best_action  <= '0;
          rsp_q.result_value <= item_q.write_value;
        end
        default: begin
          rsp_q.best_action  <= '0;
          rsp_q.result_value <= '0;
        end
      endcase
    end
  end

  assign rsp_data_o = rsp_q;

endmodule

// ===== hdl/tabular_q_learning_engine_unit.sv =====
// tabular_q_learning_engine_unit: top level of the tabular q-learning engine
// joins tqle_ctrl and tqle_datapath, depends on tqle_pkg and tqle_if
`timescale 1ns / 1ps

// Tabular Q-learning engine. Holds a 256 x 8 table of signed q8.8 action
// values in a single-port memory; every entry reads as -10.0 once the
// clearing pass after reset is over. That pass writes one entry a cycle,
// and no request beat is taken while it runs (configuration writes are
// taken at any time). A request beat carries one op and yields exactly one
// response beat. Learn moves q(s,a) toward reward plus, with bootstrap set,
// discount times the best value of the next state, by the learning rate,
// with round half up and saturation to 16 bits. Choose returns the best
// action of a state (lowest index on ties) and its value. Write stores one
// entry; op 3 returns zeros. One op is in flight at a time, and the table
// port delivers one entry per cycle. Learn with bootstrap scans the next
// state's row first; every learn then reads q(s,a), forms target, delta and
// step and writes the new value; choose scans the row. A finished response
// sits in an output register, so the next request is accepted while it waits.
// learning_rate (index 0) and discount (index 1) are q1.15, values above
// 1.0 act as 1.0; write them only while the engine is idle.

module tabular_q_learning_engine_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tqle_req_if.sink                       req_i,
  tqle_rsp_if.source                     rsp_o,
  input  logic                           cfg_we_i,
  input  logic [tqle_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tqle_pkg::RATE_W-1:0]    cfg_data_i
);
  import tqle_pkg::*;

  // command bundle from the sequencer to the datapath
  tqle_cmd_t cmd;

  // sequencer: clear sweep, action scan, learn arithmetic steps, result beat
  tqle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_op_i     (req_i.data.op),
    .in_boot_i   (req_i.data.bootstrap),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  // table memory, max search, two multiplies and the response register
  tqle_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_data_i (req_i.data),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rsp_data_o (rsp_o.data)
  );

endmodule

// ===== test/tqle_q_checker.sv =====
// tqle_q_checker: watches the request, response and configuration ports of the engine,
// keeps its own q table and rates, predicts every response beat and compares it
// depends on tqle_pkg and tqle_if
`timescale 1ns / 1ps

module tqle_q_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tqle_req_if                            req_i,
  tqle_rsp_if                            rsp_i,
  input  logic                           cfg_we_i,
  input  logic [tqle_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tqle_pkg::RATE_W-1:0]    cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import tqle_pkg::*;

  logic signed [VALUE_W-1:0] q_shadow [Q_DEPTH];
  logic [RATE_W-1:0]         alpha_q;
  logic [RATE_W-1:0]         gamma_q;
  tqle_rsp_t                 expected_rsp_q [$];

  // round half up: add 2^14, floor shift by 15
  function automatic longint round_q15(input longint x);
    return (x + 64'sd16384) >>> 15;
  endfunction

  // rates above 1.0 act as 1.0
  function automatic longint rate_clamped(input logic [RATE_W-1:0] r);
    return (r > ONE_Q15) ? longint'(ONE_Q15) : longint'(r);
  endfunction

  // best value of a state, scan starts at action 0, lowest index wins ties
  function automatic logic [ACTION_W-1:0] best_action_of(input logic [STATE_W-1:0] s,
                                                         output longint best);
    logic [ACTION_W-1:0] arg;
    arg  = '0;
    best = q_shadow[{s, arg}];
    for (int i = 1; i < ACTIONS; i++) begin
      if (q_shadow[{s, ACTION_W'(i)}] > best) begin
        best = q_shadow[{s, ACTION_W'(i)}];
        arg  = ACTION_W'(i);
      end
    end
    return arg;
  endfunction

  task automatic apply_to_table(input tqle_req_t r, output tqle_rsp_t e);
    logic [Q_ADDR_W-1:0] idx;
    longint              old_q;
    longint              target;
    longint              best;
    longint              updated;
    idx = {r.state_index, r.action_index};
    e   = '0;
    case (r.op)
      OP_LEARN: begin
        old_q  = q_shadow[idx];
        target = $signed(r.reward);
        if (r.bootstrap) begin
          void'(best_action_of(r.next_state, best));
          target = target + round_q15(best * rate_clamped(gamma_q));
        end
        updated = old_q + round_q15((target - old_q) * rate_clamped(alpha_q));
        if (updated > 32767) updated = 32767;
        else if (updated < -32768) updated = -32768;
        q_shadow[idx]  = updated[VALUE_W-1:0];
        e.result_value = updated[VALUE_W-1:0];
      end
      OP_CHOOSE: begin
        e.best_action  = best_action_of(r.state_index, best);
        e.result_value = best[VALUE_W-1:0];
      end
      OP_WRITE: begin
        q_shadow[idx]  = r.write_value;
        e.result_value = r.write_value;
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tqle_rsp_t expected;
    if (!rst_ni) begin
      for (int i = 0; i < Q_DEPTH; i++) q_shadow[i] = Q_RESET_VALUE;
      alpha_q = LEARNING_RATE_RST;
      gamma_q = DISCOUNT_RST;
      expected_rsp_q.delete();
    end else begin
      // response first, so a stray beat is never matched with this edge's request
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("response beat with nothing expected");
        end else begin
          expected = expected_rsp_q.pop_front();
          if (rsp_i.data.best_action !== expected.best_action)
            report_mismatch($sformatf("best_action %0d, expected %0d",
                                      rsp_i.data.best_action, expected.best_action));
          if (rsp_i.data.result_value !== expected.result_value)
            report_mismatch($sformatf("result_value %0d, expected %0d",
                                      rsp_i.data.result_value, expected.result_value));
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_LEARNING_RATE) alpha_q = cfg_data_i;
        else if (cfg_idx_i == CFG_DISCOUNT) gamma_q = cfg_data_i;
      end
      if (req_i.valid && req_i.ready) begin
        apply_to_table(req_i.data, expected);
        expected_rsp_q.push_back(expected);
      end
    end
    pending_o = expected_rsp_q.size();
  end

endmodule

// ===== test/testbench.sv =====
// testbench: stimulus and verdict for tabular_q_learning_engine_unit
// drives requests, backpressure and rate registers, checking is done by tqle_q_checker
// depends on tqle_pkg, tqle_if, the engine rtl and test/tqle_q_checker.sv
`timescale 1ns / 1ps

module testbench;
  import tqle_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 310;

  // rates of the random phases, the random-rate phase overrides its entry
  localparam logic [RATE_W-1:0] PHASE_ALPHA [PHASES] =
    '{LEARNING_RATE_RST, ONE_Q15, 16'd0, 16'hFFFF, 16'd0, 16'd16384};
  localparam logic [RATE_W-1:0] PHASE_GAMMA [PHASES] =
    '{DISCOUNT_RST, ONE_Q15, 16'd0, 16'hFFFF, 16'd0, 16'd1};
  localparam int RANDOM_RATE_PHASE = 4;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [RATE_W-1:0]    cfg_data;
  int                   fail_count;
  int                   pending;
  int                   send_gap_pct;
  int                   recv_gap_pct;

  tqle_req_if req_ch ();
  tqle_rsp_if rsp_ch ();

  tabular_q_learning_engine_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  tqle_q_checker q_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop, several times the slowest legal run including the clearing pass
  initial begin
    #2_000_000;
    $display("timeout with %0d response beats outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: ready redrawn every falling edge from the current stall rate
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = ($urandom_range(99) >= recv_gap_pct);
    end
  end

  function automatic tqle_req_t make_request(input tqle_op_e op,
                                             input int s, input int a,
                                             input int reward, input int ns,
                                             input bit boot, input int wval);
    tqle_req_t r;
    r.op           = op;
    r.state_index  = STATE_W'(s);
    r.action_index = ACTION_W'(a);
    r.reward       = VALUE_W'(reward);
    r.next_state   = STATE_W'(ns);
    r.bootstrap    = boot;
    r.write_value  = VALUE_W'(wval);
    return r;
  endfunction

  // mostly a small pool of states so learns, writes and chooses hit the same rows
  function automatic logic [STATE_W-1:0] pick_state();
    int pick;
    pick = $urandom_range(9);
    if (pick < 7) return STATE_W'($urandom_range(15));
    else if (pick == 7) return STATE_W'(STATES - 1);
    else return STATE_W'($urandom);
  endfunction

  function automatic tqle_req_t random_request();
    tqle_req_t r;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 45) r.op = OP_LEARN;
    else if (pick < 70) r.op = OP_CHOOSE;
    else if (pick < 92) r.op = OP_WRITE;
    else r.op = OP_NOP;
    r.state_index  = pick_state();
    r.action_index = ACTION_W'($urandom_range(ACTIONS - 1));
    // half moderate values, half the full signed range
    r.reward       = $urandom_range(1) ? VALUE_W'($urandom_range(4095) - 2048)
                                       : VALUE_W'($urandom);
    r.next_state   = pick_state();
    r.bootstrap    = 1'($urandom_range(1));
    r.write_value  = $urandom_range(1) ? VALUE_W'($urandom_range(8191) - 4096)
                                       : VALUE_W'($urandom);
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken;
  // valid stays high so back-to-back beats need no second assignment
  task automatic send_request(input tqle_req_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid = 1'b0;
      req_ch.data  = random_request();  // noise while idle
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.data  = r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off until every response beat is back, then let the engine settle
  task automatic wait_for_drain();
    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [RATE_W-1:0] value);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  task automatic set_rates(input logic [RATE_W-1:0] alpha, input logic [RATE_W-1:0] gamma);
    write_register(CFG_LEARNING_RATE, alpha);
    write_register(CFG_DISCOUNT, gamma);
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_LEARNING_RATE;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    send_gap_pct = 21;
    recv_gap_pct = 84;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed part at the reset rates; the first beat waits out the clearing pass
    send_request(make_request(OP_CHOOSE, 0, 0, 0, 0, 1'b0, 0));           // all ties
    send_request(make_request(OP_LEARN, 0, 0, 0, 0, 1'b0, 0));
    send_request(make_request(OP_WRITE, 255, 7, 0, 0, 1'b0, 32767));
    send_request(make_request(OP_WRITE, 255, 3, 0, 0, 1'b0, 32767));
    send_request(make_request(OP_CHOOSE, 255, 0, 0, 0, 1'b0, 0));         // tie, lower wins
    // all values negative: max must come from the row, not from zero
    send_request(make_request(OP_WRITE, 2, 0, 0, 0, 1'b0, -32768));
    send_request(make_request(OP_CHOOSE, 2, 0, 0, 0, 1'b0, 0));
    send_request(make_request(OP_LEARN, 0, 1, 32767, 255, 1'b1, 0));
    send_request(make_request(OP_LEARN, 3, 2, -32768, 2, 1'b1, 0));
    send_request(make_request(OP_LEARN, 5, 5, -32768, 9, 1'b0, 0));
    send_request(make_request(OP_NOP, 255, 7, -1, 255, 1'b1, -1));        // unused op
    send_request(make_request(OP_LEARN, 255, 7, 32767, 255, 1'b1, 0));

    // alpha and gamma at exactly one: saturation both ways
    wait_for_drain();
    set_rates(ONE_Q15, ONE_Q15);
    send_request(make_request(OP_LEARN, 255, 3, 32767, 255, 1'b1, 0));
    send_request(make_request(OP_LEARN, 2, 0, -32768, 2, 1'b1, 0));
    send_request(make_request(OP_CHOOSE, 2, 0, 0, 0, 1'b0, 0));

    // rates above one act as one
    wait_for_drain();
    set_rates(16'hFFFF, 16'hFFFF);
    send_request(make_request(OP_LEARN, 6, 4, 12345, 255, 1'b1, 0));
    send_request(make_request(OP_LEARN, 7, 0, -1, 0, 1'b0, 0));

    // zero learning rate leaves the table alone
    wait_for_drain();
    set_rates(16'd0, 16'd0);
    send_request(make_request(OP_LEARN, 255, 7, -32768, 2, 1'b1, 0));
    send_request(make_request(OP_CHOOSE, 255, 0, 0, 0, 1'b0, 0));

    // random phases: idling pattern changes every two phases, rates every phase
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_drain();
      if (phase == RANDOM_RATE_PHASE) set_rates(RATE_W'($urandom), RATE_W'($urandom));
      else set_rates(PHASE_ALPHA[phase], PHASE_GAMMA[phase]);
      if (phase < 2) begin
        send_gap_pct = 21;
        recv_gap_pct = 84;
      end else if (phase < 4) begin
        send_gap_pct = 84;
        recv_gap_pct = 21;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // now and then stop sending until the engine has answered everything
        if ($urandom_range(199) == 0) wait_for_drain();
        send_request(random_request());
      end
    end

    wait_for_drain();
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tqle_pkg.sv
hdl/tqle_if.sv
hdl/tqle_ctrl.sv
hdl/tqle_datapath.sv
hdl/tabular_q_learning_engine_unit.sv
test/tqle_q_checker.sv
test/testbench.sv
